>>> sv/psrg_pkg.sv
// Shared types, constants and the divider step for the stencil row generator.
`timescale 1ns / 1ps
package psrg_pkg;

	localparam int RowW   = 24;
	localparam int ValW   = 36;
	localparam int WgtW   = 32;
	localparam int CellW  = 9;
	localparam int PlaneW = 2 * CellW;
	localparam int TotalW = 3 * CellW;
	localparam int Slots  = 7;
	localparam int IdxW   = 3;
	localparam int CfgW   = 32;

	// Register indexes of the configuration port.
	localparam logic [IdxW-1:0] RegMode    = 3'd0;
	localparam logic [IdxW-1:0] RegXCells  = 3'd1;
	localparam logic [IdxW-1:0] RegYCells  = 3'd2;
	localparam logic [IdxW-1:0] RegZCells  = 3'd3;
	localparam logic [IdxW-1:0] RegXWeight = 3'd4;
	localparam logic [IdxW-1:0] RegYWeight = 3'd5;
	localparam logic [IdxW-1:0] RegZWeight = 3'd6;

	// Entry slots of a row, in output order.
	localparam logic [2:0] SlotZm   = 3'd0;
	localparam logic [2:0] SlotYm   = 3'd1;
	localparam logic [2:0] SlotXm   = 3'd2;
	localparam logic [2:0] SlotDiag = 3'd3;
	localparam logic [2:0] SlotZp   = 3'd4;
	localparam logic [2:0] SlotYp   = 3'd5;
	localparam logic [2:0] SlotXp   = 3'd6;

	localparam logic [ValW-1:0] OneQ16 = 36'd65536;

	localparam int QueueDepth = 4;
	localparam int QPtrW      = 2;
	localparam int QCntW      = 3;

	typedef struct packed {
		logic             per;
		logic             ok;
		logic [CellW-1:0] nx;
		logic [CellW-1:0] ny;
		logic [CellW-1:0] nz;
		logic [WgtW-1:0]  wx;
		logic [WgtW-1:0]  wy;
		logic [WgtW-1:0]  wz;
	} cfg_t;

	typedef struct packed {
		logic [Slots-1:0][RowW-1:0] cols;
		logic signed [ValW-1:0]     diag;
		logic [Slots-1:0]           mask;
		logic                       bad;
	} entry_t;

	typedef struct packed {
		logic [RowW-1:0]   row;
		logic [PlaneW-1:0] plane;
		logic [TotalW-1:0] total;
		logic [RowW-1:0]   rem;
		logic [CellW-1:0]  k;
		logic [CellW-1:0]  j;
		logic              in_range;
	} pipe_t;

	typedef struct packed {
		logic [RowW-1:0] rem;
		logic [2:0]      q;
	} div_t;

	// Three restoring division steps, quotient bits top down to top-2.
	function automatic div_t div3(logic [RowW-1:0] rem, logic [PlaneW-1:0] dvs,
		logic [3:0] top);
		logic [TotalW-1:0] r;
		logic [TotalW-1:0] d;
		div_t              res;
		r = {3'b000, rem};
		res.q = 3'b000;
		for (int s = 0; s < 3; s++) begin
			d = {{(TotalW-PlaneW){1'b0}}, dvs} << (top - 4'(s));
			if (r >= d) begin
				r = r - d;
				res.q[2-s] = 1'b1;
			end
		end
		res.rem = r[RowW-1:0];
		return res;
	endfunction

endpackage

>>> sv/psrg_row_if.sv
// Row request channel: one row index per beat.
`timescale 1ns / 1ps
interface psrg_row_if;
	logic                        valid;
	logic                        ready;
	logic [psrg_pkg::RowW-1:0]   row_index;

	modport source(output valid, output row_index, input ready);
	modport sink(input valid, input row_index, output ready);
endinterface

>>> sv/psrg_entry_if.sv
// Matrix entry channel: one column and value pair per beat.
`timescale 1ns / 1ps
interface psrg_entry_if;
	logic                               valid;
	logic                               ready;
	logic [psrg_pkg::RowW-1:0]          column_index;
	logic signed [psrg_pkg::ValW-1:0]   entry_value;
	logic                               last_entry;
	logic                               bad_row;

	modport source(output valid, output column_index, output entry_value,
		output last_entry, output bad_row, input ready);
	modport sink(input valid, input column_index, input entry_value,
		input last_entry, input bad_row, output ready);
endinterface

>>> sv/psrg_front.sv
// Front pipeline: splits a row index into cell coordinates and builds its entry set.
`timescale 1ns / 1ps
module psrg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  psrg_pkg::cfg_t   cfg,
	psrg_row_if.sink         rows,
	output logic             push,
	output psrg_pkg::entry_t push_entry,
	input  logic             full
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	psrg_pkg::pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7;
	psrg_pkg::pipe_t n1, n2, n3, n4, n5, n6, n7;
	psrg_pkg::entry_t e_s8, n8;
	psrg_pkg::div_t d2, d3, d4, d5, d6, d7;

	logic [psrg_pkg::CellW-1:0] ci, cj, ck;
	logic i_lo, i_hi, j_lo, j_hi, k_lo, k_hi, bad, ref_cell;
	logic [psrg_pkg::TotalW-1:0] row_w, pl_w, tot_w, nx_w;
	logic [psrg_pkg::ValW-1:0] ax, ay, az, wx_w, wy_w, wz_w;

	// The whole pipe moves together; it halts only when its last stage
	// holds an entry set that the queue cannot take.
	assign en         = !v_s8 || !full;
	assign rows.ready = en;
	assign push       = v_s8 && !full;
	assign push_entry = e_s8;

	always_comb begin
		n1 = '0;
		n1.row   = rows.row_index;
		n1.rem   = rows.row_index;
		n1.plane = psrg_pkg::PlaneW'(cfg.nx) * psrg_pkg::PlaneW'(cfg.ny);

		n2 = p_s1;
		n2.total = psrg_pkg::TotalW'(p_s1.plane) * psrg_pkg::TotalW'(cfg.nz);
		d2 = psrg_pkg::div3(p_s1.rem, p_s1.plane, 4'd8);
		n2.rem = d2.rem;
		n2.k[8:6] = d2.q;

		n3 = p_s2;
		n3.in_range = {3'b000, p_s2.row} < p_s2.total;
		d3 = psrg_pkg::div3(p_s2.rem, p_s2.plane, 4'd5);
		n3.rem = d3.rem;
		n3.k[5:3] = d3.q;

		n4 = p_s3;
		d4 = psrg_pkg::div3(p_s3.rem, p_s3.plane, 4'd2);
		n4.rem = d4.rem;
		n4.k[2:0] = d4.q;

		n5 = p_s4;
		d5 = psrg_pkg::div3(p_s4.rem, {9'd0, cfg.nx}, 4'd8);
		n5.rem = d5.rem;
		n5.j[8:6] = d5.q;

		n6 = p_s5;
		d6 = psrg_pkg::div3(p_s5.rem, {9'd0, cfg.nx}, 4'd5);
		n6.rem = d6.rem;
		n6.j[5:3] = d6.q;

		n7 = p_s6;
		d7 = psrg_pkg::div3(p_s6.rem, {9'd0, cfg.nx}, 4'd2);
		n7.rem = d7.rem;
		n7.j[2:0] = d7.q;
	end

	// Classification of the cell and the neighbour columns.
	always_comb begin
		ci = p_s7.rem[psrg_pkg::CellW-1:0];
		cj = p_s7.j;
		ck = p_s7.k;
		bad  = !cfg.ok || !p_s7.in_range;
		i_lo = ci == '0;
		j_lo = cj == '0;
		k_lo = ck == '0;
		i_hi = ci == cfg.nx - 9'd1;
		j_hi = cj == cfg.ny - 9'd1;
		k_hi = ck == cfg.nz - 9'd1;
		if (cfg.per) begin
			ref_cell = ci == {1'b0, cfg.nx[8:1]} && cj == {1'b0, cfg.ny[8:1]} &&
				ck == {1'b0, cfg.nz[8:1]};
		end else begin
			ref_cell = ci == 9'd1 && cj == 9'd1 && ck == 9'd1;
		end

		row_w = {3'b000, p_s7.row};
		pl_w  = {9'd0, p_s7.plane};
		tot_w = p_s7.total;
		nx_w  = {18'd0, cfg.nx};

		n8.cols[psrg_pkg::SlotZm] = k_lo ? 24'(row_w + tot_w - pl_w) : 24'(row_w - pl_w);
		n8.cols[psrg_pkg::SlotYm] = j_lo ? 24'(row_w + pl_w - nx_w) : 24'(row_w - nx_w);
		n8.cols[psrg_pkg::SlotXm] = i_lo ? 24'(row_w + nx_w - 27'd1) : 24'(row_w - 27'd1);
		n8.cols[psrg_pkg::SlotDiag] = bad ? '0 : p_s7.row;
		n8.cols[psrg_pkg::SlotZp] = k_hi ? 24'(row_w - (tot_w - pl_w)) : 24'(row_w + pl_w);
		n8.cols[psrg_pkg::SlotYp] = j_hi ? 24'(row_w - (pl_w - nx_w)) : 24'(row_w + nx_w);
		n8.cols[psrg_pkg::SlotXp] = i_hi ? 24'(row_w - (nx_w - 27'd1)) : 24'(row_w + 27'd1);

		wx_w = {4'd0, cfg.wx};
		wy_w = {4'd0, cfg.wy};
		wz_w = {4'd0, cfg.wz};
		ax = (!cfg.per && (i_lo || i_hi)) ? wx_w : wx_w << 1;
		ay = (!cfg.per && (j_lo || j_hi)) ? wy_w : wy_w << 1;
		az = (!cfg.per && (k_lo || k_hi)) ? wz_w : wz_w << 1;

		n8.bad = bad;
		if (bad) begin
			n8.mask = 7'd1 << psrg_pkg::SlotDiag;
			n8.diag = '0;
		end else if (ref_cell) begin
			n8.mask = 7'd1 << psrg_pkg::SlotDiag;
			n8.diag = psrg_pkg::OneQ16;
		end else begin
			n8.diag = -(ax + ay + az);
			if (cfg.per) begin
				n8.mask = '1;
			end else begin
				n8.mask = {!i_hi, !j_hi, !k_hi, 1'b1, !i_lo, !j_lo, !k_lo};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= rows.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= n1;
			p_s2 <= n2;
			p_s3 <= n3;
			p_s4 <= n4;
			p_s5 <= n5;
			p_s6 <= n6;
			p_s7 <= n7;
			e_s8 <= n8;
		end
	end

endmodule

>>> sv/psrg_queue.sv
// Small queue of entry sets between the front pipeline and the entry walker.
`timescale 1ns / 1ps
module psrg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psrg_pkg::entry_t wdata,
	output logic             full,
	input  logic             pop,
	output psrg_pkg::entry_t rdata,
	output logic             empty
);

	psrg_pkg::entry_t mem [psrg_pkg::QueueDepth];
	psrg_pkg::entry_t rdata_q;
	logic [psrg_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q, rd_next;
	logic [psrg_pkg::QCntW-1:0] cnt_q;
	logic                       bypass;

	assign full  = cnt_q == psrg_pkg::QCntW'(psrg_pkg::QueueDepth);
	assign empty = cnt_q == '0;
	assign rdata = rdata_q;

	// The head register always holds the oldest stored set. A push into a
	// queue that is empty once this cycle's pop is done goes straight to it.
	assign rd_next = rd_ptr_q + psrg_pkg::QPtrW'(pop);
	assign bypass  = push && (cnt_q == psrg_pkg::QCntW'(pop));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
		if (bypass) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[rd_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/psrg_back.sv
// Entry walker: emits the set entries of one row, one beat per cycle while the entry channel takes them.
`timescale 1ns / 1ps
module psrg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  psrg_pkg::cfg_t   cfg,
	input  psrg_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	psrg_entry_if.source     entries
);

	psrg_pkg::entry_t cur_q;
	logic             cur_v_q;
	logic [psrg_pkg::Slots-1:0] rem_q;

	logic                        ov_q, olast_q, obad_q;
	logic [psrg_pkg::RowW-1:0]   ocol_q;
	logic signed [psrg_pkg::ValW-1:0] oval_q;

	logic [2:0]                  sel;
	logic                        found, last, adv, load_next;
	logic [psrg_pkg::Slots-1:0]  onehot;
	logic signed [psrg_pkg::ValW-1:0] val;

	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int s = 0; s < psrg_pkg::Slots; s++) begin
			if (!found && rem_q[s]) begin
				sel   = 3'(s);
				found = 1'b1;
			end
		end
		onehot = 7'd1 << sel;
		last   = (rem_q & ~onehot) == '0;
		case (sel)
			psrg_pkg::SlotZm, psrg_pkg::SlotZp: val = {4'd0, cfg.wz};
			psrg_pkg::SlotYm, psrg_pkg::SlotYp: val = {4'd0, cfg.wy};
			psrg_pkg::SlotXm, psrg_pkg::SlotXp: val = {4'd0, cfg.wx};
			default:                            val = cur_q.diag;
		endcase
	end

	assign adv       = cur_v_q && (!ov_q || entries.ready);
	assign load_next = !cur_v_q || (adv && last);
	assign pop       = load_next && !empty;

	assign entries.valid        = ov_q;
	assign entries.column_index = ocol_q;
	assign entries.entry_value  = oval_q;
	assign entries.last_entry   = olast_q;
	assign entries.bad_row      = obad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (load_next) begin
				cur_v_q <= !empty;
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (entries.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ocol_q  <= cur_q.cols[sel];
			oval_q  <= val;
			olast_q <= last;
			obad_q  <= cur_q.bad;
		end
		if (pop) begin
			cur_q <= head;
			rem_q <= head.mask;
		end else if (adv) begin
			rem_q <= rem_q & ~onehot;
		end
	end

endmodule

>>> sv/poisson_stencil_row_gen.sv
// Top level of the seven-point Laplacian row generator: registers, front, queue, walker.
`timescale 1ns / 1ps
//
//  Channel   Side   Beat carries
//  --------  -----  --------------------------------------------------------
//  rows      sink   row_index (24 bits)
//  entries   source column_index, entry_value (signed Q20.16), last_entry, bad_row
//  cfg_*     write  cfg_we, cfg_index, cfg_data; no stall, no read-back
//
//  A row beat is taken every cycle while the front pipeline can move; it then
//  passes the front stages and the queue to the walker. Each row gives one to
//  seven entry beats, one per cycle while entries is not stalled, so the
//  sustained row rate is bound by the single entry output port.
//  Reset restores the register defaults and empties the pipeline and queue.
//  A stall on entries fills the queue and then halts the whole front pipeline.
//
module poisson_stencil_row_gen #(
	parameter int MAX_AXIS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [psrg_pkg::IdxW-1:0]     cfg_index,
	input  logic [psrg_pkg::CfgW-1:0]     cfg_data,
	psrg_row_if.sink                      rows,
	psrg_entry_if.source                  entries
);

	// Largest accepted cell count along any axis.
	localparam logic [10:0] MaxAxisW = 11'(MAX_AXIS);

	logic                        mode_q;
	logic [psrg_pkg::CellW-1:0]  xc_q, yc_q, zc_q;
	logic [psrg_pkg::WgtW-1:0]   xw_q, yw_q, zw_q;

	psrg_pkg::cfg_t   cfg;
	psrg_pkg::entry_t q_wdata, q_rdata;
	logic             q_push, q_full, q_pop, q_empty;
	logic             x_ok, y_ok, z_ok, tiny;

	// Configuration registers. Writes beyond the register list fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			xc_q   <= 9'd8;
			yc_q   <= 9'd8;
			zc_q   <= 9'd8;
			xw_q   <= 32'd65536;
			yw_q   <= 32'd65536;
			zw_q   <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				psrg_pkg::RegMode:    mode_q <= cfg_data[0];
				psrg_pkg::RegXCells:  xc_q   <= cfg_data[8:0];
				psrg_pkg::RegYCells:  yc_q   <= cfg_data[8:0];
				psrg_pkg::RegZCells:  zc_q   <= cfg_data[8:0];
				psrg_pkg::RegXWeight: xw_q   <= cfg_data;
				psrg_pkg::RegYWeight: yw_q   <= cfg_data;
				psrg_pkg::RegZWeight: zw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grid geometry as the pipeline sees it. The user must change the registers
	// only while the block is idle; the block itself does not enforce this, and
	// only then does this stay constant for every row in flight. A rejected setup
	// collapses the grid to one cell, and every row index is flagged bad anyway.
	always_comb begin
		x_ok = xc_q != '0 && {2'b00, xc_q} <= MaxAxisW;
		y_ok = yc_q != '0 && {2'b00, yc_q} <= MaxAxisW;
		z_ok = zc_q != '0 && {2'b00, zc_q} <= MaxAxisW;
		tiny = xc_q < 9'd3 || yc_q < 9'd3 || zc_q < 9'd3;
		cfg.per = mode_q;
		cfg.ok  = x_ok && y_ok && z_ok && !(mode_q && tiny);
		cfg.nx  = !cfg.ok ? 9'd1 : (mode_q ? xc_q - 9'd2 : xc_q);
		cfg.ny  = !cfg.ok ? 9'd1 : (mode_q ? yc_q - 9'd2 : yc_q);
		cfg.nz  = !cfg.ok ? 9'd1 : (mode_q ? zc_q - 9'd2 : zc_q);
		cfg.wx  = xw_q;
		cfg.wy  = yw_q;
		cfg.wz  = zw_q;
	end

	// The front divides the row index into (i, j, k) over six stages and
	// then classifies the cell into a set of up to seven entries.
	psrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.rows       (rows),
		.push       (q_push),
		.push_entry (q_wdata),
		.full       (q_full)
	);

	psrg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// The walker emits the set entries in slot order through a registered
	// output stage and pulls the next set as the last entry leaves.
	psrg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (q_rdata),
		.empty   (q_empty),
		.pop     (q_pop),
		.entries (entries)
	);

	// Row input is held off only when the queue is full.
	a_ready_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rows.ready |-> q_full)
		else $error("row input stalled with room in the queue");

	// The walker never pulls from an empty queue.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("queue popped while empty");

	// The queue can only become full through a push.
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(q_full) |-> $past(q_push))
		else $error("queue became full without a push");

endmodule

>>> tb/poisson_stencil_row_gen_tb.sv
// Self-checking testbench for the seven-point Laplacian row generator.
`timescale 1ns / 1ps
//
// Rows are queued by the stimulus process, driven by a clocked driver and
// predicted at the beat where the block takes them. A clocked monitor takes
// entry beats and compares them with the oldest predicted entry. Each phase
// starts from an idle block: registers are written first, then rows go out,
// then the testbench waits until every predicted entry has come back.
//
module poisson_stencil_row_gen_tb;

	localparam int MaxAxis = 256;
	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 16;
	localparam int RandomPhases = 12;
	localparam int RowsPerPhase = 24;

	localparam logic ModeNeumann  = 1'b0;
	localparam logic ModePeriodic = 1'b1;

	// Index 7 is not a register; writes to it must leave every register alone.
	localparam logic [psrg_pkg::IdxW-1:0] RegUnused = 3'd7;

	localparam longint ValFloor = -(longint'(1) << 35);

	typedef struct packed {
		logic [psrg_pkg::RowW-1:0]        column_index;
		logic signed [psrg_pkg::ValW-1:0] entry_value;
		logic                             last_entry;
		logic                             bad_row;
	} matrix_entry_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [psrg_pkg::IdxW-1:0] cfg_index;
	logic [psrg_pkg::CfgW-1:0] cfg_data;

	psrg_row_if   row_bus();
	psrg_entry_if entry_bus();

	poisson_stencil_row_gen #(
		.MAX_AXIS(MaxAxis)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rows(row_bus.sink),
		.entries(entry_bus.source)
	);

	// Shadow copy of the register file, updated as each write is driven.
	logic                       boundary_mode_q;
	logic [psrg_pkg::CellW-1:0] x_cells_q;
	logic [psrg_pkg::CellW-1:0] y_cells_q;
	logic [psrg_pkg::CellW-1:0] z_cells_q;
	logic [psrg_pkg::WgtW-1:0]  x_weight_q;
	logic [psrg_pkg::WgtW-1:0]  y_weight_q;
	logic [psrg_pkg::WgtW-1:0]  z_weight_q;

	logic [psrg_pkg::RowW-1:0] rows_to_send[$];
	matrix_entry_t             expected_entries[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Grid size as the block sees it. Periodic mode works on the configured
	// size minus the two ghost layers and needs at least three on every axis.
	function automatic bit grid_shape(output longint nx, output longint ny,
		output longint nz);
		bit per;
		bit ok;
		per = boundary_mode_q == ModePeriodic;
		ok = x_cells_q >= 1 && x_cells_q <= MaxAxis && y_cells_q >= 1 &&
			y_cells_q <= MaxAxis && z_cells_q >= 1 && z_cells_q <= MaxAxis;
		if (per && (x_cells_q < 3 || y_cells_q < 3 || z_cells_q < 3))
			ok = 1'b0;
		nx = per ? longint'(x_cells_q) - 2 : longint'(x_cells_q);
		ny = per ? longint'(y_cells_q) - 2 : longint'(y_cells_q);
		nz = per ? longint'(z_cells_q) - 2 : longint'(z_cells_q);
		return ok;
	endfunction

	function automatic matrix_entry_t make_entry(longint col, longint val);
		matrix_entry_t e;
		e.column_index = col[psrg_pkg::RowW-1:0];
		e.entry_value = val[psrg_pkg::ValW-1:0];
		e.last_entry = 1'b0;
		e.bad_row = 1'b0;
		return e;
	endfunction

	// The diagonal is never positive; a magnitude beyond Q20.16 pins to the floor.
	function automatic longint clamp_diag(longint d);
		return d < ValFloor ? ValFloor : d;
	endfunction

	// Works out every entry of one row and appends them to the expected list.
	function automatic void predict_row(logic [psrg_pkg::RowW-1:0] row_in);
		longint nx, ny, nz, plane, row, i, j, k;
		longint wx, wy, wz, diag;
		matrix_entry_t row_q[$];
		bit ok;
		ok = grid_shape(nx, ny, nz);
		plane = nx * ny;
		row = row_in;
		wx = x_weight_q;
		wy = y_weight_q;
		wz = z_weight_q;
		if (!ok || row >= plane * nz) begin
			// A rejected row is a single flagged entry with zero column and value.
			row_q.push_back(make_entry(0, 0));
			row_q[0].bad_row = 1'b1;
		end else begin
			k = row / plane;
			j = (row % plane) / nx;
			i = row % nx;
			if (boundary_mode_q == ModePeriodic) begin
				if (i == nx / 2 && j == ny / 2 && k == nz / 2) begin
					// The centre cell pins the pressure level.
					row_q.push_back(make_entry(row, psrg_pkg::OneQ16));
				end else begin
					// Neighbours wrap; on a one- or two-cell axis they may land on
					// the row itself or repeat, and are still sent separately.
					row_q.push_back(make_entry(((k + nz - 1) % nz) * plane + j * nx + i, wz));
					row_q.push_back(make_entry(k * plane + ((j + ny - 1) % ny) * nx + i, wy));
					row_q.push_back(make_entry(k * plane + j * nx + (i + nx - 1) % nx, wx));
					row_q.push_back(make_entry(row, clamp_diag(-2 * (wx + wy + wz))));
					row_q.push_back(make_entry(((k + 1) % nz) * plane + j * nx + i, wz));
					row_q.push_back(make_entry(k * plane + ((j + 1) % ny) * nx + i, wy));
					row_q.push_back(make_entry(k * plane + j * nx + (i + 1) % nx, wx));
				end
			end else if (i == 1 && j == 1 && k == 1) begin
				row_q.push_back(make_entry(row, psrg_pkg::OneQ16));
			end else begin
				// Closed walls: a missing neighbour also drops one weight from
				// the diagonal on that axis.
				diag = 0;
				diag -= (i == 0 || i == nx - 1) ? wx : 2 * wx;
				diag -= (j == 0 || j == ny - 1) ? wy : 2 * wy;
				diag -= (k == 0 || k == nz - 1) ? wz : 2 * wz;
				if (k > 0) row_q.push_back(make_entry(row - plane, wz));
				if (j > 0) row_q.push_back(make_entry(row - nx, wy));
				if (i > 0) row_q.push_back(make_entry(row - 1, wx));
				row_q.push_back(make_entry(row, clamp_diag(diag)));
				if (k + 1 < nz) row_q.push_back(make_entry(row + plane, wz));
				if (j + 1 < ny) row_q.push_back(make_entry(row + nx, wy));
				if (i + 1 < nx) row_q.push_back(make_entry(row + 1, wx));
			end
		end
		row_q[row_q.size() - 1].last_entry = 1'b1;
		foreach (row_q[n])
			expected_entries.push_back(row_q[n]);
	endfunction

	// Drives one register write; the enable stays high into the next write so
	// that back-to-back writes never drop and raise it in the same step.
	task automatic write_register(logic [psrg_pkg::IdxW-1:0] idx,
		logic [psrg_pkg::CfgW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			psrg_pkg::RegMode:    boundary_mode_q = data[0];
			psrg_pkg::RegXCells:  x_cells_q = data[psrg_pkg::CellW-1:0];
			psrg_pkg::RegYCells:  y_cells_q = data[psrg_pkg::CellW-1:0];
			psrg_pkg::RegZCells:  z_cells_q = data[psrg_pkg::CellW-1:0];
			psrg_pkg::RegXWeight: x_weight_q = data[psrg_pkg::WgtW-1:0];
			psrg_pkg::RegYWeight: y_weight_q = data[psrg_pkg::WgtW-1:0];
			psrg_pkg::RegZWeight: z_weight_q = data[psrg_pkg::WgtW-1:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_grid(logic mode, int xc, int yc, int zc);
		write_register(psrg_pkg::RegMode, psrg_pkg::CfgW'(mode));
		write_register(psrg_pkg::RegXCells, psrg_pkg::CfgW'(xc));
		write_register(psrg_pkg::RegYCells, psrg_pkg::CfgW'(yc));
		write_register(psrg_pkg::RegZCells, psrg_pkg::CfgW'(zc));
	endtask

	task automatic write_weights(logic [psrg_pkg::WgtW-1:0] wx,
		logic [psrg_pkg::WgtW-1:0] wy, logic [psrg_pkg::WgtW-1:0] wz);
		write_register(psrg_pkg::RegXWeight, wx);
		write_register(psrg_pkg::RegYWeight, wy);
		write_register(psrg_pkg::RegZWeight, wz);
	endtask

	// Phase changes happen on the falling edge, away from the driver and monitor.
	task automatic begin_phase(int send_idle, int recv_stall);
		@(negedge clk);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
	endtask

	// Returns once every queued row is taken and every entry has come back,
	// then lets the pipeline settle before the registers may change again.
	task automatic wait_idle();
		while (rows_to_send.size() != 0 || row_bus.valid || expected_entries.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// Axis sizes for random phases: mostly small valid grids, now and then an
	// empty, too small, full-size or out-of-range axis.
	function automatic logic [psrg_pkg::CellW-1:0] pick_axis(logic mode);
		case ($urandom_range(31))
			0: return psrg_pkg::CellW'($urandom_range(2));
			1: return psrg_pkg::CellW'($urandom_range(511, MaxAxis + 1));
			2: return psrg_pkg::CellW'(MaxAxis);
			default: return mode == ModePeriodic ? psrg_pkg::CellW'($urandom_range(10, 3))
				: psrg_pkg::CellW'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic logic [psrg_pkg::WgtW-1:0] pick_weight();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	// Row driver: a beat holds until taken; the next row may go out right after, unless an idle beat is drawn.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bus.valid <= 1'b0;
			row_bus.row_index <= '0;
		end else begin
			if (row_bus.valid && row_bus.ready) begin
				predict_row(row_bus.row_index);
				void'(rows_to_send.pop_front());
			end
			if (!row_bus.valid || row_bus.ready) begin
				if (rows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					row_bus.valid <= 1'b1;
					row_bus.row_index <= rows_to_send[0];
				end else begin
					row_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Entry monitor: every taken beat is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_bus.ready <= 1'b0;
		end else begin
			if (entry_bus.valid && entry_bus.ready) begin : check_beat
				matrix_entry_t seen;
				matrix_entry_t want;
				seen.column_index = entry_bus.column_index;
				seen.entry_value = entry_bus.entry_value;
				seen.last_entry = entry_bus.last_entry;
				seen.bad_row = entry_bus.bad_row;
				if (expected_entries.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					$display("%0t: unexpected entry col %0d val %0d last %0b bad %0b",
						$time, seen.column_index, seen.entry_value, seen.last_entry,
						seen.bad_row);
				end else begin
					want = expected_entries.pop_front();
					if (seen.column_index !== want.column_index ||
						seen.entry_value !== want.entry_value ||
						seen.last_entry !== want.last_entry || seen.bad_row !== want.bad_row) begin
						mismatch_count <= mismatch_count + 1;
						$write("%0t: entry mismatch, expected col %0d val %0d last %0b bad %0b",
							$time, want.column_index, want.entry_value, want.last_entry,
							want.bad_row);
						$display(", got col %0d val %0d last %0b bad %0b",
							seen.column_index, seen.entry_value, seen.last_entry,
							seen.bad_row);
					end
				end
			end
			entry_bus.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		longint nx, ny, nz, cells;
		bit shape_ok;
		logic mode;
		logic [31:0] pick;
		int send_pcts[4];
		int stall_pcts[4];
		send_pcts = '{0, 65, 0, 13};
		stall_pcts = '{0, 0, 65, 13};

		boundary_mode_q = ModeNeumann;
		x_cells_q = 9'd8;
		y_cells_q = 9'd8;
		z_cells_q = 9'd8;
		x_weight_q = 32'h0001_0000;
		y_weight_q = 32'h0001_0000;
		z_weight_q = 32'h0001_0000;
		cfg_we = 1'b0;
		cfg_index = psrg_pkg::RegMode;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset values: closed 8x8x8 grid, unit weights. Corners, the reference
		// cell (1,1,1), an interior cell, the last cell and two rows past the end.
		begin_phase(0, 0);
		rows_to_send = '{24'd0, 24'd7, 24'd73, 24'd146, 24'd511, 24'd512, 24'hFF_FFFF};
		wait_idle();

		// Periodic 3x4x5 reduces to 1x2x3, so wrapped neighbours fold onto the
		// row itself. The reference cell is (0,1,1), row 3; row 6 is past the end.
		// The unused index is written last and must change nothing.
		write_grid(ModePeriodic, 3, 4, 5);
		write_weights(32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
		write_register(RegUnused, '1);
		close_writes();
		begin_phase(0, 0);
		rows_to_send = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6};
		wait_idle();

		// Largest closed grid with the largest weights: every row index is in range
		// and the interior diagonal reaches its biggest magnitude.
		write_grid(ModeNeumann, MaxAxis, MaxAxis, MaxAxis);
		write_weights('1, '1, '1);
		close_writes();
		begin_phase(0, 0);
		rows_to_send = '{24'd0, 24'hFF_FFFF, 24'h01_0101, 24'hAA_AAAA, 24'h55_5555};
		wait_idle();

		// Single-cell closed grid: one diagonal-only row, anything else is bad.
		write_grid(ModeNeumann, 1, 1, 1);
		write_weights('0, '1, 32'd1);
		close_writes();
		begin_phase(0, 0);
		rows_to_send = '{24'd0, 24'd1};
		wait_idle();

		// Empty and oversized axes reject every row.
		write_grid(ModeNeumann, 0, MaxAxis + 1, 4);
		close_writes();
		begin_phase(0, 0);
		rows_to_send = '{24'd0};
		wait_idle();

		// Periodic with a two-cell axis is also rejected.
		write_grid(ModePeriodic, 3, 2, 3);
		close_writes();
		begin_phase(0, 0);
		rows_to_send = '{24'd0};
		wait_idle();

		// Random phases: fresh settings each time, with junk in the unused upper
		// data bits, and the idle pattern cycling through all four mixes.
		for (int p = 0; p < RandomPhases; p++) begin
			mode = $urandom_range(1);
			write_register(psrg_pkg::RegMode,
				($urandom() & ~32'h1) | psrg_pkg::CfgW'(mode));
			write_register(psrg_pkg::RegXCells,
				($urandom() & ~32'h1FF) | psrg_pkg::CfgW'(pick_axis(mode)));
			write_register(psrg_pkg::RegYCells,
				($urandom() & ~32'h1FF) | psrg_pkg::CfgW'(pick_axis(mode)));
			write_register(psrg_pkg::RegZCells,
				($urandom() & ~32'h1FF) | psrg_pkg::CfgW'(pick_axis(mode)));
			write_weights(pick_weight(), pick_weight(), pick_weight());
			if ($urandom_range(3) == 0)
				write_register(RegUnused, $urandom());
			close_writes();
			shape_ok = grid_shape(nx, ny, nz);
			cells = shape_ok ? nx * ny * nz : 0;
			begin_phase(send_pcts[p % 4], stall_pcts[p % 4]);
			// Mostly rows inside the grid; the rest are any 24-bit index.
			for (int n = 0; n < RowsPerPhase; n++) begin
				if (cells > 0 && $urandom_range(99) < 85)
					pick = $urandom_range(32'(cells - 1));
				else
					pick = $urandom();
				rows_to_send.push_back(pick[psrg_pkg::RowW-1:0]);
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
